FILE: rtl/core/obb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: shared package
// Transaction types, fixed-point widths, CORDIC table and rounding helper.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int TRIG_FRAC    = (COORD_BITS > 45) ? 61 - COORD_BITS : 16;
  localparam int CORDIC_STEPS = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  localparam int ZW  = 33;
  localparam int XYW = 34;
  localparam int TW  = TRIG_FRAC + 2;
  localparam int MW  = TW + COORD_BITS + 1;
  localparam int EW  = COORD_BITS + 2;
  localparam int CW  = COORD_BITS + 3;
  localparam int QW  = CW + TW;
  localparam int PW  = QW + 1;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int BOX_LAT    = 2;
  localparam int PROJ_LAT   = 4;
  localparam int OBB_LAT    = CORDIC_LAT + BOX_LAT + PROJ_LAT + 1;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [31:0] a_center_x;
    logic signed [31:0] a_center_y;
    logic [31:0]        a_width;
    logic [31:0]        a_height;
    logic [15:0]        a_angle;
    logic signed [31:0] b_center_x;
    logic signed [31:0] b_center_y;
    logic [31:0]        b_width;
    logic [31:0]        b_height;
    logic [15:0]        b_angle;
  } obb_in_t;

  typedef struct packed {
    logic boxes_overlap;
    logic a_axes_clear;
    logic b_axes_clear;
  } obb_out_t;

  typedef struct packed {
    logic [3:0][CW-1:0] px;
    logic [3:0][CW-1:0] py;
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
    logic w_zero;
    logic h_zero;
  } box_t;

  // Shift right with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] half;
    logic [63:0] m;
    half = 64'd1 << (sh - 1);
    if (v < 0) begin
      m = $unsigned(-v);
      rnd_shift = -$signed((m + half) >> sh);
    end else begin
      m = $unsigned(v);
      rnd_shift = $signed((m + half) >> sh);
    end
  endfunction

endpackage

FILE: rtl/core/obb_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: pipelined sine and cosine
// One CORDIC rotation step per register stage, then quadrant fold and rounding.
// ----------------------------------------------------------------------------
module obb_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [obb_pkg::ANGLE_BITS-1:0]    angle_i,
  output logic                              valid_o,
  output logic signed [obb_pkg::TW-1:0]     cos_o,
  output logic signed [obb_pkg::TW-1:0]     sin_o
);
  import obb_pkg::*;

  logic [CORDIC_STEPS:0]  vld_q;
  logic signed [XYW-1:0]  x_q [CORDIC_STEPS+1];
  logic signed [XYW-1:0]  y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0]   z_q [CORDIC_STEPS+1];
  logic [1:0]             quad_q [CORDIC_STEPS+1];
  logic [31:0]            phase;
  logic signed [XYW-1:0]  rc, rs;
  logic                   out_vld_q;
  logic signed [TW-1:0]   cos_q, sin_q;

  assign phase = 32'(angle_i) << (32 - ANGLE_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= XYW'(CORDIC_GAIN);
    y_q[0]    <= '0;
    z_q[0]    <= ZW'(phase[29:0]);
    quad_q[0] <= phase[31:30];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XYW-1:0] xs, ys;
    logic signed [ZW-1:0]  at;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = ZW'(ATAN_TURN[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + at;
      end
      quad_q[i+1] <= quad_q[i];
    end
  end

  always_comb begin
    case (quad_q[CORDIC_STEPS])
      2'd0: begin
        rc = x_q[CORDIC_STEPS];
        rs = y_q[CORDIC_STEPS];
      end
      2'd1: begin
        rc = -y_q[CORDIC_STEPS];
        rs = x_q[CORDIC_STEPS];
      end
      2'd2: begin
        rc = -x_q[CORDIC_STEPS];
        rs = -y_q[CORDIC_STEPS];
      end
      default: begin
        rc = y_q[CORDIC_STEPS];
        rs = -x_q[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= TW'(rnd_shift(64'(rc), 30 - TRIG_FRAC));
    sin_q <= TW'(rnd_shift(64'(rs), 30 - TRIG_FRAC));
  end

  assign valid_o = out_vld_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

FILE: rtl/core/obb_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: corner builder
// Scales the unit edge directions by half the box size and forms the four corners.
// ----------------------------------------------------------------------------
module obb_box (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [obb_pkg::TW-1:0]       cos_i,
  input  logic signed [obb_pkg::TW-1:0]       sin_i,
  input  logic signed [obb_pkg::COORD_BITS-1:0] cx_i,
  input  logic signed [obb_pkg::COORD_BITS-1:0] cy_i,
  input  logic [obb_pkg::COORD_BITS-1:0]      w_i,
  input  logic [obb_pkg::COORD_BITS-1:0]      h_i,
  output logic                                valid_o,
  output obb_pkg::box_t                       box_o
);
  import obb_pkg::*;

  logic                         v1_q, v2_q;
  logic signed [MW-1:0]         cw_q, sw_q, ch_q, sh_q;
  logic signed [TW-1:0]         c1_q, s1_q;
  logic signed [COORD_BITS-1:0] cx1_q, cy1_q;
  logic                         wz1_q, hz1_q;
  logic signed [COORD_BITS:0]   wext, hext;
  logic signed [EW-1:0]         xx, xy, yx, yy;
  logic signed [CW-1:0]         cxe, cye, xxe, xye, yxe, yye;
  box_t                         box_d, box_q;

  assign wext = $signed({1'b0, w_i});
  assign hext = $signed({1'b0, h_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q  <= MW'(cos_i) * MW'(wext);
    sw_q  <= MW'(sin_i) * MW'(wext);
    ch_q  <= MW'(cos_i) * MW'(hext);
    sh_q  <= MW'(sin_i) * MW'(hext);
    c1_q  <= cos_i;
    s1_q  <= sin_i;
    cx1_q <= cx_i;
    cy1_q <= cy_i;
    wz1_q <= (w_i == '0);
    hz1_q <= (h_i == '0);
  end

  always_comb begin
    xx  = EW'(rnd_shift(64'(cw_q), TRIG_FRAC + 1));
    xy  = EW'(rnd_shift(64'(sw_q), TRIG_FRAC + 1));
    yx  = EW'(rnd_shift(-64'(sh_q), TRIG_FRAC + 1));
    yy  = EW'(rnd_shift(64'(ch_q), TRIG_FRAC + 1));
    cxe = CW'(cx1_q);
    cye = CW'(cy1_q);
    xxe = CW'(xx);
    xye = CW'(xy);
    yxe = CW'(yx);
    yye = CW'(yy);
    box_d.px[0] = cxe - xxe - yxe;
    box_d.py[0] = cye - xye - yye;
    box_d.px[1] = cxe + xxe - yxe;
    box_d.py[1] = cye + xye - yye;
    box_d.px[2] = cxe + xxe + yxe;
    box_d.py[2] = cye + xye + yye;
    box_d.px[3] = cxe - xxe + yxe;
    box_d.py[3] = cye - xye + yye;
    box_d.c      = c1_q;
    box_d.s      = s1_q;
    box_d.w_zero = wz1_q;
    box_d.h_zero = hz1_q;
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign valid_o = v2_q;
  assign box_o   = box_q;

endmodule

FILE: rtl/core/obb_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: axis projection and interval check
// Projects both boxes onto each edge axis of the own box and tests overlap.
// ----------------------------------------------------------------------------
module obb_proj (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  obb_pkg::box_t own_i,
  input  obb_pkg::box_t oth_i,
  output logic          valid_o,
  output logic          clear_o
);
  import obb_pkg::*;

  logic [PROJ_LAT-1:0]   v_q;
  logic [1:0]            z1_q, z2_q, z3_q;
  logic signed [TW-1:0]  dx [2];
  logic signed [TW-1:0]  dy [2];
  logic signed [QW-1:0]  pmx_q [2][2][4];
  logic signed [QW-1:0]  pmy_q [2][2][4];
  logic signed [PW-1:0]  prj_q [2][2][4];
  logic signed [PW-1:0]  mn_d  [2][2];
  logic signed [PW-1:0]  mx_d  [2][2];
  logic signed [PW-1:0]  mn_q  [2][2];
  logic signed [PW-1:0]  mx_q  [2][2];
  logic                  clear_d, clear_q;

  assign dx[0] = own_i.c;
  assign dy[0] = own_i.s;
  assign dx[1] = -own_i.s;
  assign dy[1] = own_i.c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PROJ_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        pmx_q[a][0][k] <= QW'($signed(own_i.px[k])) * QW'(dx[a]);
        pmy_q[a][0][k] <= QW'($signed(own_i.py[k])) * QW'(dy[a]);
        pmx_q[a][1][k] <= QW'($signed(oth_i.px[k])) * QW'(dx[a]);
        pmy_q[a][1][k] <= QW'($signed(oth_i.py[k])) * QW'(dy[a]);
      end
    end
    z1_q <= {own_i.h_zero, own_i.w_zero};
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 4; k++) begin
          prj_q[a][j][k] <= PW'(pmx_q[a][j][k]) + PW'(pmy_q[a][j][k]);
        end
      end
    end
    z2_q <= z1_q;
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int j = 0; j < 2; j++) begin
        logic signed [PW-1:0] lo01, lo23, hi01, hi23;
        lo01 = (prj_q[a][j][1] < prj_q[a][j][0]) ? prj_q[a][j][1] : prj_q[a][j][0];
        lo23 = (prj_q[a][j][3] < prj_q[a][j][2]) ? prj_q[a][j][3] : prj_q[a][j][2];
        hi01 = (prj_q[a][j][1] > prj_q[a][j][0]) ? prj_q[a][j][1] : prj_q[a][j][0];
        hi23 = (prj_q[a][j][3] > prj_q[a][j][2]) ? prj_q[a][j][3] : prj_q[a][j][2];
        mn_d[a][j] = (lo23 < lo01) ? lo23 : lo01;
        mx_d[a][j] = (hi23 > hi01) ? hi23 : hi01;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mn_q <= mn_d;
    mx_q <= mx_d;
    z3_q <= z2_q;
  end

  always_comb begin
    clear_d = 1'b1;
    for (int a = 0; a < 2; a++) begin
      if (!z3_q[a] && ((mx_q[a][1] < mn_q[a][0]) || (mn_q[a][1] > mx_q[a][0]))) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clear_q <= clear_d;
  end

  assign valid_o = v_q[PROJ_LAT-1];
  assign clear_o = clear_q;

endmodule

FILE: rtl/core/obb2d_overlap_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: top level
// Separating axis test of two rotated boxes in Q16.16, one pair per clock.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         start, busy           item_i   (obb_in_t)
// result    out        done_o strobe         result_o (obb_out_t)
//
// A pair may be started in every cycle; busy is never raised.
// The result passes through the 24-step CORDIC
// pipeline (26 stages), the corner builder (2), the projection stages (4)
// and the output register (1).
// Reset clears all valid bits; results are strobed once and are not held.
// ----------------------------------------------------------------------------
module obb2d_overlap_test_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  obb_pkg::obb_in_t  item_i,
  output logic              busy,
  output logic              done_o,
  output obb_pkg::obb_out_t result_o
);
  import obb_pkg::*;

  obb_in_t               dly_q [CORDIC_LAT];
  obb_in_t               side;
  logic                  tv_a, tv_b, bv_a, bv_b, pv_a, pv_b;
  logic signed [TW-1:0]  ca, sa, cb, sb;
  box_t                  box_a, box_b;
  logic                  clr_a, clr_b;
  logic                  done_q;
  obb_out_t              result_q;

  always_ff @(posedge clk_i) begin
    dly_q[0] <= item_i;
    for (int i = 1; i < CORDIC_LAT; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign side = dly_q[CORDIC_LAT-1];

  obb_cordic u_trig_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .angle_i (item_i.a_angle[ANGLE_BITS-1:0]),
    .valid_o (tv_a),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  obb_cordic u_trig_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .angle_i (item_i.b_angle[ANGLE_BITS-1:0]),
    .valid_o (tv_b),
    .cos_o   (cb),
    .sin_o   (sb)
  );

  obb_box u_box_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_a),
    .cos_i   (ca),
    .sin_i   (sa),
    .cx_i    (side.a_center_x[COORD_BITS-1:0]),
    .cy_i    (side.a_center_y[COORD_BITS-1:0]),
    .w_i     (side.a_width[COORD_BITS-1:0]),
    .h_i     (side.a_height[COORD_BITS-1:0]),
    .valid_o (bv_a),
    .box_o   (box_a)
  );

  obb_box u_box_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_b),
    .cos_i   (cb),
    .sin_i   (sb),
    .cx_i    (side.b_center_x[COORD_BITS-1:0]),
    .cy_i    (side.b_center_y[COORD_BITS-1:0]),
    .w_i     (side.b_width[COORD_BITS-1:0]),
    .h_i     (side.b_height[COORD_BITS-1:0]),
    .valid_o (bv_b),
    .box_o   (box_b)
  );

  obb_proj u_proj_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bv_a),
    .own_i   (box_a),
    .oth_i   (box_b),
    .valid_o (pv_a),
    .clear_o (clr_a)
  );

  obb_proj u_proj_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bv_b),
    .own_i   (box_b),
    .oth_i   (box_a),
    .valid_o (pv_b),
    .clear_o (clr_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pv_a && pv_b;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.boxes_overlap <= clr_a && clr_b;
    result_q.a_axes_clear  <= clr_a;
    result_q.b_axes_clear  <= clr_b;
  end

  assign busy     = 1'b0;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: rtl/core/obb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
module obb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input obb_pkg::obb_out_t result_o
);
  import obb_pkg::*;

  // Every accepted transaction produces exactly one result after the fixed latency.
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##OBB_LAT done_o)
    else $error("accepted transaction produced no result");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, OBB_LAT))
    else $error("result without an accepted transaction");

  a_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.boxes_overlap ==
                (result_o.a_axes_clear && result_o.b_axes_clear)))
    else $error("overlap flag disagrees with axis flags");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind obb2d_overlap_test_top obb_checker u_obb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
